[design/smtpcr_pkg.sv]
// Shared types and constants for the mail session command responder.
package smtpcr_pkg;

    // Input event codes. Code 3 carries no meaning and is ignored.
    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_OPEN = 2'd2
    } action_t;

    // Reply codes driven on the result channel.
    typedef enum logic [2:0] {
        RPL_WELCOME = 3'd0,
        RPL_OK      = 3'd1,
        RPL_RCPT    = 3'd2,
        RPL_CAPS    = 3'd3,
        RPL_DATA    = 3'd4,
        RPL_QUEUED  = 3'd5,
        RPL_CLOSED  = 3'd6
    } reply_t;

    // Register index decoded from the configuration address.
    localparam logic REG_IDLE_LIMIT = 1'b0;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd500;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    // Command patterns, lower case; lines are folded before the compare.
    localparam int PAT_DATA_LEN = 6;
    localparam int PAT_RCPT_LEN = 8;
    localparam int PAT_EHLO_LEN = 5;
    localparam int PAT_QUIT_LEN = 6;

    localparam logic [7:0] PAT_DATA [PAT_DATA_LEN] = '{"d", "a", "t", "a", 8'd13, 8'd10};
    localparam logic [7:0] PAT_RCPT [PAT_RCPT_LEN] = '{"r", "c", "p", "t", " ", "t", "o", ":"};
    localparam logic [7:0] PAT_EHLO [PAT_EHLO_LEN] = '{"e", "h", "l", "o", " "};
    localparam logic [7:0] PAT_QUIT [PAT_QUIT_LEN] = '{"q", "u", "i", "t", 8'd13, 8'd10};

    // Map upper case ASCII letters to lower case; all other bytes pass.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z")
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

[design/smtp_command_responder.sv]
// Top level of the mail session command responder: line assembly, command match, replies.

// Server side of a minimal mail session. Each input word is an event: a
// received byte, an idle tick or a connection open. Bytes are gathered into
// lines ended by CR LF; the first PREFIX_BYTES bytes of each line are kept and
// matched without regard to case. In command mode a finished line gives start
// data ("DATA" CR LF, enters data mode), recipient ok ("RCPT TO:"), the
// capability list ("EHLO "), or default ok; exactly "QUIT" CR LF gives default
// ok followed by closed and ends the session. In data mode only a line that is
// exactly "." CR LF gets a reply (queued) and it returns to command mode. More
// idle ticks in a row than idle_limit close the session with a closed reply.
// An open event always (re)starts the session with a welcome reply. Bytes and
// ticks outside a session produce nothing. Each result word carries a reply
// code and a last flag that marks the final reply caused by one input word.
// Timing: an input word is captured in an input register, decoded in a single
// pass of combinational logic and its reply lands in the output register, so
// one word is taken every clock while the result side keeps up. The output
// register holds one reply; for a QUIT line, which produces two replies, the
// input side waits until the closed reply has followed the ok reply into it.
// A reply is loaded into the output register when the word in the input
// register is processed. The idle_limit register sits at byte address 0 of the
// APB port and should only be written while no words are in flight.
module smtp_command_responder
    import smtpcr_pkg::*;
#(
    parameter int PREFIX_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Input word channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  rx_byte,

    // Result word channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  reply,
    output logic        last,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LEN_W = $clog2(PREFIX_BYTES + 1);

    // Configuration.
    logic [15:0]      idle_limit_reg;

    // Input register.
    logic             in_valid_reg;
    action_t          act_reg;
    logic [7:0]       byte_reg;

    // Session state.
    logic             session_reg, session_next;
    logic             data_mode_reg, data_mode_next;
    logic [7:0]       pfx_reg [PREFIX_BYTES];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             cr_reg, cr_next;
    logic [15:0]      idle_reg, idle_next;

    // Output register and the pending closed reply that follows QUIT.
    logic             out_valid_reg, out_valid_next;
    reply_t           reply_reg, reply_next;
    logic             last_reg, last_next;
    logic             pend_reg, pend_next;

    // Line view with the current byte placed.
    logic [7:0]       pfx_ins [PREFIX_BYTES];
    logic [LEN_W-1:0] len_ins;
    logic             line_end;
    logic             m_data, m_rcpt, m_ehlo, m_quit, m_dot;
    logic [16:0]      idle_inc;

    // Result of processing the registered word.
    logic             res_valid;
    reply_t           res_reply;
    logic             res_last;
    logic             res_quit;
    logic             byte_store;

    logic             slot_free;
    logic             proc_fire;

    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_IDLE_LIMIT)
        begin
            prdata = {16'd0, idle_limit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE_LIMIT)
        begin
            idle_limit_reg <= pwdata[15:0];
        end
    end

    // The output register can take a reply when it is empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;
    assign proc_fire = in_valid_reg && slot_free && !pend_reg;
    assign in_ready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= action_t'(action);
            byte_reg <= rx_byte;
        end
    end

    // Place the incoming byte at the current length, saturating at the prefix size.
    always_comb
    begin
        for (int i = 0; i < PREFIX_BYTES; i++)
        begin
            pfx_ins[i] = (len_reg == LEN_W'(i)) ? byte_reg : pfx_reg[i];
        end
        if (len_reg < LEN_W'(PREFIX_BYTES))
        begin
            len_ins = LEN_W'(len_reg + 1'b1);
        end
        else
        begin
            len_ins = len_reg;
        end
    end

    assign line_end = cr_reg && (byte_reg == CHAR_LF);

    // Command matches on the line including the current byte.
    always_comb
    begin
        m_data = (len_ins >= LEN_W'(PAT_DATA_LEN));
        for (int i = 0; i < PAT_DATA_LEN; i++)
        begin
            if (fold_case(pfx_ins[i]) != PAT_DATA[i])
            begin
                m_data = 1'b0;
            end
        end
        m_rcpt = (len_ins >= LEN_W'(PAT_RCPT_LEN));
        for (int i = 0; i < PAT_RCPT_LEN; i++)
        begin
            if (fold_case(pfx_ins[i]) != PAT_RCPT[i])
            begin
                m_rcpt = 1'b0;
            end
        end
        m_ehlo = (len_ins >= LEN_W'(PAT_EHLO_LEN));
        for (int i = 0; i < PAT_EHLO_LEN; i++)
        begin
            if (fold_case(pfx_ins[i]) != PAT_EHLO[i])
            begin
                m_ehlo = 1'b0;
            end
        end
        m_quit = (len_ins >= LEN_W'(PAT_QUIT_LEN));
        for (int i = 0; i < PAT_QUIT_LEN; i++)
        begin
            if (fold_case(pfx_ins[i]) != PAT_QUIT[i])
            begin
                m_quit = 1'b0;
            end
        end
        // The end of data marker is compared exactly, without folding.
        m_dot = (len_ins == LEN_W'(3)) && (pfx_ins[0] == CHAR_DOT)
                && (pfx_ins[1] == CHAR_CR) && (pfx_ins[2] == CHAR_LF);
    end

    assign idle_inc = {1'b0, idle_reg} + 17'd1;

    // Session update for the word in the input register.
    always_comb
    begin
        session_next   = session_reg;
        data_mode_next = data_mode_reg;
        len_next       = len_reg;
        cr_next        = cr_reg;
        idle_next      = idle_reg;
        byte_store     = 1'b0;
        res_valid      = 1'b0;
        res_reply      = RPL_OK;
        res_last       = 1'b1;
        res_quit       = 1'b0;
        if (proc_fire)
        begin
            unique case (act_reg)
                ACT_OPEN:
                begin
                    session_next   = 1'b1;
                    data_mode_next = 1'b0;
                    len_next       = '0;
                    cr_next        = 1'b0;
                    idle_next      = '0;
                    res_valid      = 1'b1;
                    res_reply      = RPL_WELCOME;
                end
                ACT_TICK:
                begin
                    if (session_reg)
                    begin
                        if (idle_inc > {1'b0, idle_limit_reg})
                        begin
                            session_next   = 1'b0;
                            data_mode_next = 1'b0;
                            len_next       = '0;
                            cr_next        = 1'b0;
                            idle_next      = '0;
                            res_valid      = 1'b1;
                            res_reply      = RPL_CLOSED;
                        end
                        else
                        begin
                            idle_next = idle_inc[15:0];
                        end
                    end
                end
                ACT_BYTE:
                begin
                    if (session_reg)
                    begin
                        idle_next  = '0;
                        byte_store = 1'b1;
                        len_next   = len_ins;
                        cr_next    = (byte_reg == CHAR_CR);
                        if (line_end)
                        begin
                            len_next = '0;
                            cr_next  = 1'b0;
                            if (data_mode_reg)
                            begin
                                if (m_dot)
                                begin
                                    data_mode_next = 1'b0;
                                    res_valid      = 1'b1;
                                    res_reply      = RPL_QUEUED;
                                end
                            end
                            else if (m_data)
                            begin
                                data_mode_next = 1'b1;
                                res_valid      = 1'b1;
                                res_reply      = RPL_DATA;
                            end
                            else if (m_rcpt)
                            begin
                                res_valid = 1'b1;
                                res_reply = RPL_RCPT;
                            end
                            else if (m_ehlo)
                            begin
                                res_valid = 1'b1;
                                res_reply = RPL_CAPS;
                            end
                            else if (m_quit)
                            begin
                                session_next = 1'b0;
                                idle_next    = '0;
                                res_valid    = 1'b1;
                                res_reply    = RPL_OK;
                                res_last     = 1'b0;
                                res_quit     = 1'b1;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                                res_reply = RPL_OK;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= 1'b0;
            data_mode_reg <= 1'b0;
            len_reg       <= '0;
            cr_reg        <= 1'b0;
            idle_reg      <= '0;
        end
        else
        begin
            session_reg   <= session_next;
            data_mode_reg <= data_mode_next;
            len_reg       <= len_next;
            cr_reg        <= cr_next;
            idle_reg      <= idle_next;
        end
    end

    // Prefix bytes are only read below the line length, so they need no clearing.
    always_ff @(posedge clk)
    begin
        if (byte_store)
        begin
            for (int i = 0; i < PREFIX_BYTES; i++)
            begin
                pfx_reg[i] <= pfx_ins[i];
            end
        end
    end

    // Output register: the pending closed reply goes out before any new word.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        reply_next     = reply_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        if (pend_reg && slot_free)
        begin
            out_valid_next = 1'b1;
            reply_next     = RPL_CLOSED;
            last_next      = 1'b1;
            pend_next      = 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_next = 1'b1;
            reply_next     = res_reply;
            last_next      = res_last;
            pend_next      = res_quit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reply_reg <= reply_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign reply     = reply_reg;
    assign last      = last_reg;

endmodule
